// ===== design/cra_pkg.sv =====
// cra_pkg: types, constants and helpers shared by the region allocator
// used by cra_cell, cra_ctrl and contiguous_region_allocator_core
package cra_pkg;

    // table geometry
    localparam int MAX_REGIONS = 64;
    localparam int IDX_W       = $clog2(MAX_REGIONS);
    localparam int CNT_W       = IDX_W + 1;

    // page rounding, page size is a power of two
    localparam int PAGE_SHIFT  = 12;
    localparam int PAGE_BYTES  = 1 << PAGE_SHIFT;

    localparam int ADDR_W      = 32;
    localparam int OWNER_W     = 8;
    localparam int SIZE_W      = ADDR_W + 1;

    localparam logic [ADDR_W-1:0] MEM_RESET = 32'd1048576;

    // input codes
    localparam logic       ACT_REQUEST = 1'b0;
    localparam logic       ACT_RELEASE = 1'b1;
    localparam logic [1:0] FIT_FIRST   = 2'd0;
    localparam logic [1:0] FIT_BEST    = 2'd1;
    localparam logic [1:0] FIT_WORST   = 2'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_FIT    = 3'd1,
        ST_ZERO      = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_APPLY,
        S_RELEASE,
        S_COMPACT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                action;
        logic [OWNER_W-1:0]  owner_id;
        logic [ADDR_W-1:0]   request_bytes;
        logic [1:0]          fit_strategy;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [ADDR_W-1:0]   base_address;
    } t_out_item;

    // one region of the table
    typedef struct packed {
        logic                valid;
        logic                used;
        logic [OWNER_W-1:0]  owner;
        logic [ADDR_W-1:0]   start_addr;
        logic [ADDR_W-1:0]   last_addr;
    } t_entry;

    // controls broadcast to every cell
    typedef struct packed {
        logic init;
        logic rotate;
        logic compact;
    } t_chain_ctl;

    localparam t_entry ENTRY_NONE = '0;

    // single free region covering the whole memory
    function automatic t_entry init_entry(input logic [ADDR_W-1:0] mem_bytes);
        t_entry e;
        e            = ENTRY_NONE;
        e.valid      = 1'b1;
        e.last_addr  = (mem_bytes == '0) ? '0 : mem_bytes - 1'b1;
        return e;
    endfunction

endpackage

// ===== design/cra_cell.sv =====
// cra_cell: one region slot of the allocator chain
// depends on cra_pkg
module cra_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cra_pkg::t_chain_ctl  i_ctl,
    input  cra_pkg::t_entry      i_init,
    input  cra_pkg::t_entry      i_right,
    input  logic                 i_hole,
    output cra_pkg::t_entry      o_entry,
    output logic                 o_hole
);

    cra_pkg::t_entry r_entry;
    logic            shift;

    // a hole at or left of this slot pulls the slot left during compaction
    assign o_hole  = i_hole | ~r_entry.valid;
    assign shift   = i_ctl.rotate | (i_ctl.compact & o_hole);
    assign o_entry = r_entry;

    // slot register, loaded on reset and table init
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            r_entry <= i_init;
        end else if (shift) begin
            r_entry <= i_right;
        end
    end

endmodule

// ===== design/cra_ctrl.sv =====
// cra_ctrl: sequencer that scans, splits, frees and merges the region chain
// depends on cra_pkg
module cra_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_in_valid,
    input  cra_pkg::t_in_item    i_in_item,
    output logic                 o_in_ready,
    input  logic                 i_out_free,
    output logic                 o_res_load,
    output cra_pkg::t_out_item   o_res,
    input  cra_pkg::t_entry      i_head,
    output cra_pkg::t_entry      o_tail,
    output cra_pkg::t_chain_ctl  o_ctl
);

    localparam logic [cra_pkg::IDX_W-1:0] LAST_STEP =
        cra_pkg::IDX_W'(cra_pkg::MAX_REGIONS - 1);
    localparam logic [cra_pkg::CNT_W-1:0] FULL_COUNT =
        cra_pkg::CNT_W'(cra_pkg::MAX_REGIONS);

    cra_pkg::t_state   r_state, n_state;
    logic [cra_pkg::IDX_W-1:0]   r_step, n_step;
    cra_pkg::t_in_item r_item, n_item;
    logic [cra_pkg::SIZE_W-1:0]  r_need, n_need;
    logic                        r_pick_found, n_pick_found;
    logic [cra_pkg::IDX_W-1:0]   r_pick_idx, n_pick_idx;
    logic [cra_pkg::SIZE_W-1:0]  r_pick_size, n_pick_size;
    logic [cra_pkg::ADDR_W-1:0]  r_base, n_base;
    logic [cra_pkg::CNT_W-1:0]   r_count, n_count;
    logic [cra_pkg::CNT_W-1:0]   r_new_cnt, n_new_cnt;
    cra_pkg::t_entry   r_acc, n_acc;
    logic                        r_acc_v, n_acc_v;
    logic                        r_found, n_found;
    cra_pkg::t_status  r_status, n_status;

    logic [cra_pkg::SIZE_W-1:0]  head_size;
    logic [cra_pkg::SIZE_W-1:0]  round_sum;
    logic                        fits;
    logic                        take;
    logic                        split;
    logic                        match;
    cra_pkg::t_entry   freed;
    cra_pkg::t_entry   part;

    // size of the region at the head of the chain and the owner match
    assign head_size = {1'b0, i_head.last_addr} - {1'b0, i_head.start_addr} + 1'b1;
    assign fits      = i_head.valid & ~i_head.used & (head_size >= r_need);
    assign split     = (r_pick_size != r_need);
    assign match     = i_head.valid & i_head.used & (i_head.owner == r_item.owner_id);
    assign round_sum = {1'b0, i_in_item.request_bytes}
                     + cra_pkg::SIZE_W'(cra_pkg::PAGE_BYTES - 1);

    assign o_res.status       = r_status;
    assign o_res.base_address = r_base;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cra_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, chain controls and the item emitted into the tail
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_item       = r_item;
        n_need       = r_need;
        n_pick_found = r_pick_found;
        n_pick_idx   = r_pick_idx;
        n_pick_size  = r_pick_size;
        n_base       = r_base;
        n_count      = r_count;
        n_new_cnt    = r_new_cnt;
        n_acc        = r_acc;
        n_acc_v      = r_acc_v;
        n_found      = r_found;
        n_status     = r_status;
        o_in_ready   = (r_state == cra_pkg::S_IDLE);
        o_res_load   = 1'b0;
        o_tail       = i_head;
        o_ctl        = '0;
        o_ctl.init   = i_cfg_we;
        take         = 1'b0;
        freed        = i_head;
        part         = i_head;

        unique case (r_state)
            cra_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_item       = i_in_item;
                    n_step       = '0;
                    n_pick_found = 1'b0;
                    n_acc_v      = 1'b0;
                    n_new_cnt    = '0;
                    n_found      = 1'b0;
                    n_base       = '0;
                    n_need       = (round_sum >> cra_pkg::PAGE_SHIFT) << cra_pkg::PAGE_SHIFT;
                    if (i_in_item.action == cra_pkg::ACT_RELEASE) begin
                        n_state = cra_pkg::S_RELEASE;
                    end else if (i_in_item.request_bytes == '0) begin
                        n_status = cra_pkg::ST_ZERO;
                        n_state  = cra_pkg::S_DONE;
                    end else begin
                        n_state = cra_pkg::S_SCAN;
                    end
                end
            end

            // one full turn of the chain, judging the head slot each cycle
            cra_pkg::S_SCAN: begin
                o_ctl.rotate = 1'b1;
                n_step       = r_step + 1'b1;
                if (fits) begin
                    priority case (r_item.fit_strategy)
                        cra_pkg::FIT_FIRST: take = ~r_pick_found;
                        cra_pkg::FIT_BEST:  take = ~r_pick_found | (head_size < r_pick_size);
                        cra_pkg::FIT_WORST: take = ~r_pick_found | (head_size > r_pick_size);
                        default:            take = 1'b0;
                    endcase
                end
                if (take) begin
                    n_pick_found = 1'b1;
                    n_pick_idx   = r_step;
                    n_pick_size  = head_size;
                    n_base       = i_head.start_addr;
                end
                if (r_step == LAST_STEP) begin
                    n_state = cra_pkg::S_DECIDE;
                end
            end

            cra_pkg::S_DECIDE: begin
                n_step  = '0;
                n_acc_v = 1'b0;
                if (!r_pick_found) begin
                    n_status = cra_pkg::ST_NO_FIT;
                    n_base   = '0;
                    n_state  = cra_pkg::S_DONE;
                end else if (split && (r_count == FULL_COUNT)) begin
                    n_status = cra_pkg::ST_FULL;
                    n_base   = '0;
                    n_state  = cra_pkg::S_DONE;
                end else begin
                    n_state = cra_pkg::S_APPLY;
                end
            end

            // second turn: mark the pick, insert the remainder behind it
            cra_pkg::S_APPLY: begin
                o_ctl.rotate = 1'b1;
                n_step       = r_step + 1'b1;
                if (r_step < r_pick_idx) begin
                    o_tail = i_head;
                end else if (r_step == r_pick_idx) begin
                    part       = i_head;
                    part.used  = 1'b1;
                    part.owner = r_item.owner_id;
                    if (split) begin
                        part.last_addr = i_head.start_addr + r_need[cra_pkg::ADDR_W-1:0] - 1'b1;
                        n_acc            = cra_pkg::ENTRY_NONE;
                        n_acc.valid      = 1'b1;
                        n_acc.start_addr = i_head.start_addr + r_need[cra_pkg::ADDR_W-1:0];
                        n_acc.last_addr  = i_head.last_addr;
                    end
                    n_acc_v = split;
                    o_tail  = part;
                end else if (r_acc_v) begin
                    o_tail = r_acc;
                    n_acc  = i_head;
                end else begin
                    o_tail = i_head;
                end
                if (r_step == LAST_STEP) begin
                    n_status = cra_pkg::ST_OK;
                    n_count  = r_count + cra_pkg::CNT_W'(split);
                    n_state  = cra_pkg::S_DONE;
                end
            end

            // one turn freeing the owner's regions and merging free runs
            cra_pkg::S_RELEASE: begin
                o_ctl.rotate = 1'b1;
                n_step       = r_step + 1'b1;
                if (match) begin
                    freed.used  = 1'b0;
                    freed.owner = '0;
                    n_found     = 1'b1;
                end
                if (freed.valid) begin
                    if (r_acc_v && !r_acc.used && !freed.used) begin
                        n_acc.last_addr = freed.last_addr;
                        o_tail          = cra_pkg::ENTRY_NONE;
                    end else begin
                        o_tail    = r_acc_v ? r_acc : cra_pkg::ENTRY_NONE;
                        n_acc     = freed;
                        n_acc_v   = 1'b1;
                        n_new_cnt = r_new_cnt + 1'b1;
                    end
                end else begin
                    o_tail  = r_acc_v ? r_acc : cra_pkg::ENTRY_NONE;
                    n_acc_v = 1'b0;
                end
                if (r_step == LAST_STEP) begin
                    n_count = n_new_cnt;
                    n_state = cra_pkg::S_COMPACT;
                end
            end

            // squeeze the holes left by merging out to the tail
            cra_pkg::S_COMPACT: begin
                o_ctl.compact = 1'b1;
                n_step        = r_step + 1'b1;
                o_tail        = ((r_step == '0) && r_acc_v) ? r_acc : cra_pkg::ENTRY_NONE;
                if (r_step == LAST_STEP) begin
                    n_status = r_found ? cra_pkg::ST_OK : cra_pkg::ST_NOT_FOUND;
                    n_state  = cra_pkg::S_DONE;
                end
            end

            cra_pkg::S_DONE: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_state    = cra_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = cra_pkg::S_IDLE;
            end
        endcase

        // a table init restarts the count
        if (i_cfg_we) begin
            n_count = cra_pkg::CNT_W'(1);
        end
    end

    // count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= cra_pkg::CNT_W'(1);
        end else begin
            r_count <= n_count;
        end
    end

    // working registers of the current item
    always_ff @(posedge i_clk) begin
        r_step       <= n_step;
        r_item       <= n_item;
        r_need       <= n_need;
        r_pick_found <= n_pick_found;
        r_pick_idx   <= n_pick_idx;
        r_pick_size  <= n_pick_size;
        r_base       <= n_base;
        r_new_cnt    <= n_new_cnt;
        r_acc        <= n_acc;
        r_acc_v      <= n_acc_v;
        r_found      <= n_found;
        r_status     <= n_status;
    end

endmodule

// ===== design/contiguous_region_allocator_core.sv =====
// contiguous_region_allocator_core: top level of the region allocator
// depends on cra_pkg, cra_cell and cra_ctrl
//
//  channel   signals                           moves
//  in        i_in_valid/o_in_ready/i_in_item   request or release item
//  out       o_out_valid/i_out_ready/o_out_item status and base address
//  config    i_cfg_we/i_cfg_wdata              memory size, re-inits table
//
// A request makes a scan turn of the cell chain, a decide step and an apply
// turn, and ends after the decide step when it finds no fit or the table is
// full; a zero-size request goes straight to its result, and a release makes
// a free/merge turn followed by a compaction pass over the chain.
// The 64-slot chain turns one slot per cycle.
// Reset and a config write load one free region in the same cycle.
// A result waits in the output register; the next item is taken meanwhile.
module contiguous_region_allocator_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  cra_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output cra_pkg::t_out_item   o_out_item
);

    cra_pkg::t_entry     w_entry [cra_pkg::MAX_REGIONS];
    logic                w_hole  [cra_pkg::MAX_REGIONS];
    cra_pkg::t_entry     tail;
    cra_pkg::t_entry     first_init;
    cra_pkg::t_chain_ctl ctl;
    cra_pkg::t_out_item  res;
    logic                res_load;
    logic                out_free;
    logic                r_out_valid;
    cra_pkg::t_out_item  r_out_item;

    // initial table content
    assign first_init = cra_pkg::init_entry(i_rst_n ? i_cfg_wdata : cra_pkg::MEM_RESET);
    assign out_free   = ~r_out_valid | i_out_ready;

    // chain of region slots, slot 0 is the head
    for (genvar j = 0; j < cra_pkg::MAX_REGIONS; j++) begin : g_cell
        cra_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_init  ((j == 0) ? first_init : cra_pkg::ENTRY_NONE),
            .i_right ((j == cra_pkg::MAX_REGIONS - 1) ? tail
                                                      : w_entry[(j + 1) % cra_pkg::MAX_REGIONS]),
            .i_hole  ((j == 0) ? 1'b0 : w_hole[(j + cra_pkg::MAX_REGIONS - 1)
                                               % cra_pkg::MAX_REGIONS]),
            .o_entry (w_entry[j]),
            .o_hole  (w_hole[j])
        );
    end

    cra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_ready (o_in_ready),
        .i_out_free (out_free),
        .o_res_load (res_load),
        .o_res      (res),
        .i_head     (w_entry[0]),
        .o_tail     (tail),
        .o_ctl      (ctl)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
